/* design/text_console_writer_defines.svh */
// ----------------------------------------------------------------------------
// text_console_writer_defines.svh
// Assertion macros used by the console writer RTL.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// Check a consequence in the same cycle as its trigger.
`define TCW_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its trigger.
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, command codes and character constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// Cell layout: attribute byte above character byte
	localparam int CELL_W = 16;

	// Command codes
	localparam logic [1:0] CMD_PUT   = 2'd0;
	localparam logic [1:0] CMD_CLEAR = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Character codes with special meaning
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_RETURN    = 8'h0D;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	// Attribute used for blank cells after reset
	localparam logic [7:0] ATTR_RESET = 8'h07;

	// Input transaction
	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} cmd_item_t;

	// Result transaction
	typedef struct packed {
		logic [15:0] cell_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
	} result_item_t;

	// Control sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL_COPY,
		ST_SCROLL_BLANK,
		ST_CLEAR,
		ST_DONE
	} tcw_state_t;

endpackage

/* design/text_console_writer.sv */
// Put, carriage return, backspace, newline without scroll and unused commands go from idle to done.
// A read on the screen also passes the read state, for the registered read port; a read off it does not.
// A scroll walks the whole cell memory through its one read port and one write port,
// copying each row up and then blanking the last row. Clear writes one cell a cycle.
// After reset the memory is swept to blanks with attribute 0x07, with in_ready low;
// configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// text_console_writer
// Text screen of attribute/character cells with a cursor; takes put, clear
// and read commands and returns the cursor and read data for each.
// ----------------------------------------------------------------------------
`include "text_console_writer_defines.svh"

module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  tcw_pkg::cmd_item_t    in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output tcw_pkg::result_item_t out_data
);

	localparam int NCELLS = ROWS * COLUMNS;
	localparam int AW     = $clog2(NCELLS);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);

	localparam logic [AW-1:0] LAST_CELL  = AW'(NCELLS - 1);
	localparam logic [AW-1:0] SCROLL_END = AW'(NCELLS - COLUMNS);
	localparam logic [AW-1:0] COL_STRIDE = AW'(COLUMNS);

	tcw_pkg::tcw_state_t state_q, state_d;

	logic [RW-1:0] cur_row_q, cur_row_d;
	logic [CW-1:0] cur_col_q, cur_col_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [7:0]    attr_q;
	logic [15:0]   data_q, data_d;

	logic                  out_valid_q;
	tcw_pkg::result_item_t out_data_q;
	logic                  out_load;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tcw_pkg::CELL_W-1:0]  mem_wdata;
	logic [AW-1:0]               mem_raddr;
	logic [tcw_pkg::CELL_W-1:0]  mem_rdata;

	logic [AW-1:0] put_addr;
	logic [AW-1:0] rd_addr;
	logic [CW:0]   col_inc;
	logic [RW:0]   row_inc;
	logic          col_wrap;
	logic          row_over;
	logic          rd_in_range;
	logic          is_put;
	logic          is_nl;
	logic          is_cr;
	logic          is_bs;
	logic          is_glyph;
	logic          go_scroll;
	logic [15:0]   blank_cell;

	// Cell store
	tcw_screen_mem #(
		.DEPTH(NCELLS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Decode the incoming command against the cursor
	always_comb begin
		put_addr    = AW'(cur_row_q) * COL_STRIDE + AW'(cur_col_q);
		rd_addr     = AW'(in_data.read_row) * COL_STRIDE + AW'(in_data.read_col);
		col_inc     = (CW+1)'(cur_col_q) + (CW+1)'(1);
		row_inc     = (RW+1)'(cur_row_q) + (RW+1)'(1);
		col_wrap    = col_inc >= (CW+1)'(COLUMNS);
		row_over    = row_inc >= (RW+1)'(ROWS);
		rd_in_range = (32'(in_data.read_row) < ROWS) && (32'(in_data.read_col) < COLUMNS);
		is_put      = in_data.cmd == tcw_pkg::CMD_PUT;
		is_nl       = in_data.char_code == tcw_pkg::CH_NEWLINE;
		is_cr       = in_data.char_code == tcw_pkg::CH_RETURN;
		is_bs       = in_data.char_code == tcw_pkg::CH_BACKSPACE;
		is_glyph    = is_put && !is_nl && !is_cr && !is_bs;
		go_scroll   = row_over && ((is_put && is_nl) || (is_glyph && col_wrap));
		blank_cell  = {attr_q, tcw_pkg::CH_SPACE};
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (idx_q == LAST_CELL) state_d = tcw_pkg::ST_IDLE;
			end
			tcw_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (in_data.cmd)
						tcw_pkg::CMD_PUT:   state_d = go_scroll ? tcw_pkg::ST_SCROLL_COPY
						                                        : tcw_pkg::ST_DONE;
						tcw_pkg::CMD_CLEAR: state_d = tcw_pkg::ST_CLEAR;
						tcw_pkg::CMD_READ:  state_d = rd_in_range ? tcw_pkg::ST_READ
						                                          : tcw_pkg::ST_DONE;
						default:            state_d = tcw_pkg::ST_DONE;
					endcase
				end
			end
			tcw_pkg::ST_READ: state_d = tcw_pkg::ST_DONE;
			tcw_pkg::ST_SCROLL_COPY: begin
				if (idx_q == SCROLL_END) state_d = tcw_pkg::ST_SCROLL_BLANK;
			end
			tcw_pkg::ST_SCROLL_BLANK, tcw_pkg::ST_CLEAR: begin
				if (idx_q == LAST_CELL) state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = tcw_pkg::ST_IDLE;
			end
			default: state_d = tcw_pkg::ST_INIT;
		endcase
	end

	// Outputs of the sequencer: memory access, cursor and sweep updates
	always_comb begin
		in_ready  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = blank_cell;
		mem_raddr = idx_q;
		cur_row_d = cur_row_q;
		cur_col_d = cur_col_q;
		idx_d     = idx_q;
		data_d    = data_q;
		out_load  = 1'b0;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				// sweep reset blanks into every cell
				mem_we    = 1'b1;
				mem_wdata = {tcw_pkg::ATTR_RESET, tcw_pkg::CH_SPACE};
				idx_d     = (idx_q == LAST_CELL) ? '0 : idx_q + AW'(1);
			end
			tcw_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					data_d = '0;
					idx_d  = '0;
					unique case (in_data.cmd)
						tcw_pkg::CMD_PUT: begin
							if (is_nl) begin
								cur_col_d = '0;
								if (!row_over) cur_row_d = row_inc[RW-1:0];
							end else if (is_cr) begin
								cur_col_d = '0;
							end else if (is_bs) begin
								if (cur_col_q != '0) begin
									cur_col_d = cur_col_q - CW'(1);
									mem_we    = 1'b1;
									mem_waddr = put_addr - AW'(1);
									mem_wdata = blank_cell;
								end
							end else begin
								mem_we    = 1'b1;
								mem_waddr = put_addr;
								mem_wdata = {attr_q, in_data.char_code};
								if (col_wrap) begin
									cur_col_d = '0;
									if (!row_over) cur_row_d = row_inc[RW-1:0];
								end else begin
									cur_col_d = col_inc[CW-1:0];
								end
							end
						end
						tcw_pkg::CMD_CLEAR: begin
							cur_row_d = '0;
							cur_col_d = '0;
						end
						tcw_pkg::CMD_READ: begin
							mem_raddr = rd_addr;
						end
						default: begin
							data_d = '0;
						end
					endcase
				end
			end
			tcw_pkg::ST_READ: begin
				data_d = mem_rdata;
			end
			tcw_pkg::ST_SCROLL_COPY: begin
				// read one row ahead, write the cell read in the previous cycle
				mem_raddr = (idx_q == SCROLL_END) ? idx_q : idx_q + COL_STRIDE;
				mem_we    = idx_q != '0;
				mem_waddr = idx_q - AW'(1);
				mem_wdata = mem_rdata;
				idx_d     = (idx_q == SCROLL_END) ? idx_q : idx_q + AW'(1);
			end
			tcw_pkg::ST_SCROLL_BLANK, tcw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_wdata = blank_cell;
				idx_d     = (idx_q == LAST_CELL) ? '0 : idx_q + AW'(1);
			end
			tcw_pkg::ST_DONE: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				idx_d = '0;
			end
		endcase
	end

	// Control state, sweep index, cursor, attribute and result-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcw_pkg::ST_INIT;
			idx_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			attr_q      <= tcw_pkg::ATTR_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			idx_q     <= idx_d;
			cur_row_q <= cur_row_d;
			cur_col_q <= cur_col_d;
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold read data and the result transaction
	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (out_load) begin
			out_data_q.cell_data  <= data_q;
			out_data_q.cursor_row <= 5'(cur_row_q);
			out_data_q.cursor_col <= 7'(cur_col_q);
		end
	end

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`TCW_ASSERT_IMPL(a_cursor_on_screen, 1'b1, (32'(cur_row_q) < ROWS) && (32'(cur_col_q) < COLUMNS), "cursor off screen")
	`TCW_ASSERT_NEXT(a_one_command_at_a_time, in_valid && in_ready, !in_ready, "second command taken while busy")
	`TCW_ASSERT_IMPL(a_copy_no_collision, (state_q == tcw_pkg::ST_SCROLL_COPY) && mem_we, mem_raddr != mem_waddr, "scroll read and write hit the same cell")
	`TCW_ASSERT_IMPL(a_write_on_screen, mem_we, 32'(mem_waddr) < NCELLS, "cell write beyond the screen")

endmodule

/* design/tcw_screen_mem.sv */
// ----------------------------------------------------------------------------
// tcw_screen_mem
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_mem #(
	parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [AW-1:0]             waddr,
	input  logic [tcw_pkg::CELL_W-1:0] wdata,
	input  logic [AW-1:0]             raddr,
	output logic [tcw_pkg::CELL_W-1:0] rdata
);

	logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* tb/sv/tcw_console_model_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_console_model_pkg
// Expected-screen tracker for the console writer testbench. It keeps its own
// copy of the cell store, cursor and attribute. It queues the expected
// result of every accepted command and compares it with each returned one.
// ----------------------------------------------------------------------------
package tcw_console_model_pkg;
	import tcw_pkg::*;

	// Screen geometry under test
	localparam int SCR_COLS  = COLUMNS_DEF;
	localparam int SCR_ROWS  = ROWS_DEF;
	localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;

	// Command value with no function
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	class console_scoreboard;
		logic [15:0]  cells [SCR_CELLS];
		int unsigned  row;
		int unsigned  col;
		logic [7:0]   attr;
		result_item_t expected_q [$];
		int unsigned  mismatches;
		int unsigned  checked;
		int unsigned  scrolls;
		int unsigned  clears;
		int unsigned  reads;

		function new();
			attr       = ATTR_RESET;
			row        = 0;
			col        = 0;
			mismatches = 0;
			checked    = 0;
			scrolls    = 0;
			clears     = 0;
			reads      = 0;
			foreach (cells[i]) cells[i] = {ATTR_RESET, CH_SPACE};
		endfunction

		function void set_attr(input logic [7:0] value);
			attr = value;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function logic [15:0] blank_cell();
			return {attr, CH_SPACE};
		endfunction

		// Move to the start of the next row; scroll up when past the bottom
		function void next_line();
			col = 0;
			row++;
			if (row >= SCR_ROWS) begin
				for (int i = 0; i < SCR_CELLS - SCR_COLS; i++)
					cells[i] = cells[i + SCR_COLS];
				for (int i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++)
					cells[i] = blank_cell();
				row = SCR_ROWS - 1;
				scrolls++;
			end
		endfunction

		// Apply one accepted command and queue the result it must produce
		function void note_cmd(input cmd_item_t item);
			result_item_t exp_r;
			exp_r.cell_data = '0;
			case (item.cmd)
				CMD_PUT: begin
					if (item.char_code == CH_NEWLINE) begin
						next_line();
					end else if (item.char_code == CH_RETURN) begin
						col = 0;
					end else if (item.char_code == CH_BACKSPACE) begin
						if (col > 0) begin
							col--;
							cells[row * SCR_COLS + col] = blank_cell();
						end
					end else begin
						cells[row * SCR_COLS + col] = {attr, item.char_code};
						col++;
						if (col >= SCR_COLS) next_line();
					end
				end
				CMD_CLEAR: begin
					foreach (cells[i]) cells[i] = blank_cell();
					row = 0;
					col = 0;
					clears++;
				end
				CMD_READ: begin
					reads++;
					if (item.read_row < SCR_ROWS && item.read_col < SCR_COLS)
						exp_r.cell_data = cells[item.read_row * SCR_COLS + item.read_col];
				end
				default: begin
				end
			endcase
			exp_r.cursor_row = 5'(row);
			exp_r.cursor_col = 7'(col);
			expected_q.push_back(exp_r);
		endfunction

		// Compare a returned transaction with the oldest expectation
		function void check_result(input result_item_t got);
			result_item_t want;
			if (expected_q.size() == 0) begin
				$error("result with no command outstanding: cell_data %h row %0d col %0d",
					got.cell_data, got.cursor_row, got.cursor_col);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.cell_data !== want.cell_data) begin
				$error("cell_data: expected %h, got %h", want.cell_data, got.cell_data);
				mismatches++;
			end
			if (got.cursor_row !== want.cursor_row) begin
				$error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
				mismatches++;
			end
			if (got.cursor_col !== want.cursor_col) begin
				$error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
				mismatches++;
			end
		endfunction
	endclass

endpackage

/* tb/sv/tb_text_console_writer.sv */
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives put, clear and read commands into the console writer under bursty
// input and stalling output, and checks every returned cursor and cell
// against a tracked copy of the screen, across several attribute settings.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;
	import tcw_console_model_pkg::*;

	localparam int NUM_ITEMS    = 1550;
	localparam int NUM_PHASES   = 6;
	localparam int IDLE_LIMIT   = 20000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [15:0] STALL_PATTERN = 16'b1100_1110_0011_0101;

	typedef enum int unsigned {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_PATTERN,
		RDY_SPARSE
	} ready_mode_t;

	// Command mix in parts per thousand; the remainder are puts, mostly of printable characters
	typedef struct {
		int unsigned nl;
		int unsigned cr;
		int unsigned bs;
		int unsigned rd;
		int unsigned clr;
		int unsigned bad;
	} cmd_mix_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [7:0]   cfg_data;
	logic         in_valid;
	logic         in_ready;
	cmd_item_t    in_data;
	logic         out_valid;
	logic         out_ready;
	result_item_t out_data;

	console_scoreboard board;
	ready_mode_t       ready_mode;
	logic [3:0]        ready_step;
	int unsigned       idle_cycles;
	int unsigned       sent;
	int unsigned       attr_writes;

	text_console_writer #(
		.COLUMNS(SCR_COLS),
		.ROWS   (SCR_ROWS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Stall the result channel on the current phase's pattern
	always @(negedge clk) begin
		ready_step <= ready_step + 4'd1;
		case (ready_mode)
			RDY_ALWAYS:  out_ready <= 1'b1;
			RDY_COIN:    out_ready <= 1'($urandom_range(0, 1));
			RDY_PATTERN: out_ready <= STALL_PATTERN[ready_step];
			default:     out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Check each returned transaction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result(out_data);
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
				IDLE_LIMIT, board.pending());
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic cmd_item_t make_cmd(input logic [1:0] cmd, input logic [7:0] ch,
			input logic [4:0] rr, input logic [6:0] rc);
		cmd_item_t item;
		item.cmd       = cmd;
		item.char_code = ch;
		item.read_row  = rr;
		item.read_col  = rc;
		return item;
	endfunction

	// Draw one command from the given mix; reads favor the cursor's rows
	function automatic cmd_item_t random_cmd(input cmd_mix_t mix);
		cmd_item_t   item;
		int unsigned pick;
		int unsigned bound;
		item.cmd       = CMD_PUT;
		item.char_code = 8'($urandom);
		item.read_row  = 5'($urandom);
		item.read_col  = 7'($urandom);
		pick  = $urandom_range(0, 999);
		bound = mix.nl;
		if (pick < bound) begin
			item.char_code = CH_NEWLINE;
		end else if (pick < (bound += mix.cr)) begin
			item.char_code = CH_RETURN;
		end else if (pick < (bound += mix.bs)) begin
			item.char_code = CH_BACKSPACE;
		end else if (pick < (bound += mix.rd)) begin
			item.cmd = CMD_READ;
			case ($urandom_range(0, 9))
				0: begin
					if ($urandom_range(0, 1))
						item.read_row = 5'($urandom_range(SCR_ROWS, 31));
					else
						item.read_col = 7'($urandom_range(SCR_COLS, 127));
				end
				1, 2, 3: begin
					item.read_row = 5'($urandom_range(0, SCR_ROWS - 1));
					item.read_col = 7'($urandom_range(0, SCR_COLS - 1));
				end
				default: begin
					item.read_row = 5'(board.row - $urandom_range(0, board.row > 0 ? 1 : 0));
					item.read_col = 7'($urandom_range(0, SCR_COLS - 1));
				end
			endcase
		end else if (pick < (bound += mix.clr)) begin
			item.cmd = CMD_CLEAR;
		end else if (pick < (bound += mix.bad)) begin
			item.cmd = CMD_UNUSED;
		end else if ($urandom_range(0, 9) != 0) begin
			item.char_code = 8'($urandom_range(8'h20, 8'h7E));
		end
		return item;
	endfunction

	task automatic send_cmd(input cmd_item_t item);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		board.note_cmd(item);
		sent++;
	endtask

	task automatic hold_off(input int unsigned cycles);
		repeat (cycles) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Stop sending and wait until every expected result has come back
	task automatic drain();
		hold_off(1);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_attr(input logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		board.set_attr(value);
		attr_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		cmd_mix_t    mixes [NUM_PHASES];
		logic [7:0]  attrs [NUM_PHASES];
		cmd_item_t   item;
		int unsigned count;
		int unsigned budget;
		int unsigned burst;

		board       = new();
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;
		ready_mode  = RDY_COIN;
		ready_step  = '0;
		idle_cycles = 0;
		sent        = 0;
		attr_writes = 0;

		// Phase mixes: fill to the bottom, long wrapping lines, read-heavy, clears
		mixes[0] = '{nl: 120, cr: 20, bs: 50, rd: 250, clr: 3,  bad: 10};
		mixes[1] = '{nl: 80,  cr: 20, bs: 60, rd: 250, clr: 0,  bad: 10};
		mixes[2] = '{nl: 0,   cr: 0,  bs: 10, rd: 120, clr: 0,  bad: 5};
		mixes[3] = '{nl: 60,  cr: 30, bs: 80, rd: 500, clr: 4,  bad: 10};
		mixes[4] = '{nl: 150, cr: 20, bs: 40, rd: 200, clr: 10, bad: 10};
		mixes[5] = '{nl: 90,  cr: 20, bs: 50, rd: 250, clr: 2,  bad: 10};
		attrs[0] = 8'h00;
		attrs[1] = 8'($urandom);
		attrs[2] = 8'hFF;
		attrs[3] = 8'($urandom);
		attrs[4] = ATTR_RESET;
		attrs[5] = 8'($urandom);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Write the attribute while the store is still being swept
		write_attr(8'hFF);

		// Reset contents, edge reads, every put case, unused command, clear
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'hFF, 5'(SCR_ROWS - 1), 7'(SCR_COLS - 1)));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'(SCR_ROWS), 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd0, 7'(SCR_COLS)));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd31, 7'd127));
		send_cmd(make_cmd(CMD_PUT, 8'h00, 5'd31, 7'd127));
		send_cmd(make_cmd(CMD_PUT, 8'hFF, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_PUT, 8'h41, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd2));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd1));
		send_cmd(make_cmd(CMD_PUT, CH_RETURN, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_PUT, CH_BACKSPACE, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_PUT, CH_NEWLINE, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_UNUSED, 8'hFF, 5'd31, 7'd127));
		send_cmd(make_cmd(CMD_PUT, 8'h5A, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd1, 7'd0));
		send_cmd(make_cmd(CMD_CLEAR, 8'h00, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'd0, 7'd0));
		send_cmd(make_cmd(CMD_READ, 8'h00, 5'(SCR_ROWS - 1), 7'(SCR_COLS - 1)));
		drain();

		// Random phases, each with its own attribute, mix and stall pattern
		for (int p = 0; p < NUM_PHASES; p++) begin
			ready_mode = ready_mode_t'(p % 4);
			write_attr(attrs[p]);
			count  = 0;
			budget = NUM_ITEMS / NUM_PHASES;
			while (count < budget) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && count < budget; b++) begin
					item = random_cmd(mixes[p]);
					send_cmd(item);
					count++;
				end
				hold_off($urandom_range(1, 6));
			end
			drain();
		end

		$display("sent %0d commands: %0d reads, %0d scrolls, %0d clears, %0d attribute writes",
			sent, board.reads, board.scrolls, board.clears, attr_writes);
		$display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
+incdir+design
design/tcw_pkg.sv
design/tcw_screen_mem.sv
design/text_console_writer.sv
tb/sv/tcw_console_model_pkg.sv
tb/sv/tb_text_console_writer.sv
